// File: rtl/core/frm_pkg.sv
`timescale 1ns / 1ps
package frm_pkg;

  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [CFG_IDX_BITS-1:0] REG_IDEAL_FPS       = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_MIN_US   = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_MAX_US   = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATE_MULTIPLIER = 4'd3;

  localparam int IDEAL_BITS = 8;
  localparam int WIN_BITS   = 24;
  localparam int MULT_BITS  = 5;

  localparam logic [IDEAL_BITS-1:0] IDEAL_RESET = 8'd60;
  localparam logic [WIN_BITS-1:0]   MIN_RESET   = 24'd250000;
  localparam logic [WIN_BITS-1:0]   MAX_RESET   = 24'd1000000;
  localparam logic [MULT_BITS-1:0]  MULT_RESET  = 5'd4;

  localparam int FPS_BITS      = 20;
  localparam int SCALE_BITS    = 24;
  localparam int INTERVAL_BITS = 48;
  localparam int AVG_BITS      = 56;
  localparam int TOTAL_BITS    = 32;
  localparam int FRAC_BITS     = 8;

  localparam logic [15:0] EMA_KEEP = 16'd62259;
  localparam logic [11:0] EMA_TAKE = 12'd3277;

  localparam int DIV_STEPS    = SCALE_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load_in;
    logic win;
    logic fps;
    logic ema;
    logic div_step;
    logic load_out;
  } frm_cmd_t;

  typedef struct packed {
    logic div_last;
  } frm_stat_t;

endpackage

// File: rtl/core/frm_ctrl.sv
`timescale 1ns / 1ps
module frm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output frm_pkg::frm_cmd_t  cmd,
  input  frm_pkg::frm_stat_t stat
);
  import frm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_FPS,
    ST_EMA,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = ST_WIN;
      end
      ST_WIN: begin
        cmd.win   = 1'b1;
        state_nxt = ST_FPS;
      end
      ST_FPS: begin
        cmd.fps   = 1'b1;
        state_nxt = ST_EMA;
      end
      ST_EMA: begin
        cmd.ema   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold the finished beat until the output register frees up
        cmd.load_out = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready)        out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/frm_dpath.sv
`timescale 1ns / 1ps
module frm_dpath #(
  parameter int TIME_BITS  = 48,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [frm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [frm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic [TIME_BITS-1:0]                  in_now_us,
  input  frm_pkg::frm_cmd_t                     cmd,
  output frm_pkg::frm_stat_t                    stat,
  output logic [frm_pkg::FPS_BITS-1:0]          out_fps_out,
  output logic [frm_pkg::SCALE_BITS-1:0]        out_time_scale_q16,
  output logic [frm_pkg::INTERVAL_BITS-1:0]     out_frame_interval_us,
  output logic [frm_pkg::AVG_BITS-1:0]          out_interval_avg_q8,
  output logic                                  out_window_closed,
  output logic                                  out_window_dropped,
  output logic [frm_pkg::TOTAL_BITS-1:0]        out_total_frames
);
  import frm_pkg::*;

  localparam int PROD_BITS = COUNT_BITS + MULT_BITS;

  // configuration
  logic [IDEAL_BITS-1:0] ideal_r;
  logic [WIN_BITS-1:0]   min_r;
  logic [WIN_BITS-1:0]   max_r;
  logic [MULT_BITS-1:0]  mult_r;

  // frame state
  logic [TIME_BITS-1:0]  now_r;
  logic [TIME_BITS-1:0]  wstart_r;
  logic [COUNT_BITS-1:0] frames_r;
  logic [FPS_BITS-1:0]   fps_r;
  logic [TIME_BITS-1:0]  last_r;
  logic [AVG_BITS-1:0]   avg_r;
  logic [TOTAL_BITS-1:0] total_r;
  logic                  prev_vld_r;
  logic                  avg_vld_r;

  // work registers
  logic                     closed_r, dropped_r;
  logic                     fps_sat_r;
  logic [FPS_BITS-1:0]      fps_cand_r;
  logic [INTERVAL_BITS-1:0] interval_r;
  logic [AVG_BITS-1:0]      xq_r;
  logic [16:0]              p_lo_r;
  logic [AVG_BITS-1:0]      p_ah_r;
  logic [AVG_BITS-5:0]      p_xh_r;
  logic [DIV_CNT_BITS-1:0]  div_cnt_r;
  logic [FPS_BITS-1:0]      rem_r;
  logic [SCALE_BITS-1:0]    quo_r;
  logic [FPS_BITS-1:0]      divisor_r;

  // output register
  logic [FPS_BITS-1:0]      o_fps_r;
  logic [SCALE_BITS-1:0]    o_scale_r;
  logic [INTERVAL_BITS-1:0] o_interval_r;
  logic [AVG_BITS-1:0]      o_avg_r;
  logic                     o_closed_r, o_dropped_r;
  logic [TOTAL_BITS-1:0]    o_total_r;

  // window step
  logic [TIME_BITS-1:0]  elapsed;
  logic [TIME_BITS-1:0]  min_ext, max_ext;
  logic [COUNT_BITS-1:0] frames_inc;
  logic [31:0]           frames_ext;
  logic [PROD_BITS-1:0]  prod;
  logic [39:0]           prod_ext;
  logic                  win_close, win_drop;
  logic [TIME_BITS-1:0]  interval;
  logic [63:0]           ivl64;
  logic [AVG_BITS-1:0]   xq;

  always_comb begin
    elapsed    = now_r - wstart_r;
    min_ext    = TIME_BITS'(min_r);
    max_ext    = TIME_BITS'(max_r);
    frames_inc = (frames_r == '1) ? frames_r : frames_r + 1'b1;
    frames_ext = 32'(frames_inc);
    prod       = PROD_BITS'(frames_inc) * PROD_BITS'(mult_r);
    prod_ext   = 40'(prod);
    win_close  = (elapsed > min_ext) && (elapsed < max_ext);
    win_drop   = !win_close && (elapsed > max_ext);
    interval   = now_r - last_r;
    ivl64      = 64'(interval);
    // saturate the Q8 sample when the interval overflows the average width
    if (|ivl64[63:AVG_BITS-FRAC_BITS]) xq = '1;
    else xq = {ivl64[AVG_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
  end

  // fps / divider setup
  logic [FPS_BITS-1:0] fps_new;
  logic [32:0]         lo_sum;

  always_comb begin
    fps_new = fps_r;
    if (closed_r) fps_new = fps_sat_r ? '1 : fps_cand_r;
    lo_sum = 33'(avg_r[15:0]) * 33'(EMA_KEEP) + 33'(xq_r[15:0]) * 33'(EMA_TAKE);
  end

  // divider step
  logic [FPS_BITS:0] shifted;
  logic [FPS_BITS:0] diff;
  logic              ge;

  always_comb begin
    shifted = {rem_r, quo_r[SCALE_BITS-1]};
    diff    = shifted - {1'b0, divisor_r};
    ge      = shifted >= {1'b0, divisor_r};
  end

  assign stat.div_last = (div_cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1));
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ideal_r    <= IDEAL_RESET;
      min_r      <= MIN_RESET;
      max_r      <= MAX_RESET;
      mult_r     <= MULT_RESET;
      wstart_r   <= '0;
      frames_r   <= '0;
      fps_r      <= '0;
      last_r     <= '0;
      avg_r      <= '0;
      total_r    <= '0;
      prev_vld_r <= 1'b0;
      avg_vld_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IDEAL_FPS:       ideal_r <= cfg_data[IDEAL_BITS-1:0];
          REG_WINDOW_MIN_US:   min_r   <= cfg_data[WIN_BITS-1:0];
          REG_WINDOW_MAX_US:   max_r   <= cfg_data[WIN_BITS-1:0];
          REG_RATE_MULTIPLIER: mult_r  <= cfg_data[MULT_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.win) begin
        if (win_close || win_drop) begin
          wstart_r <= now_r;
          frames_r <= '0;
        end else begin
          frames_r <= frames_inc;
        end
      end
      if (cmd.fps) fps_r <= fps_new;
      if (cmd.ema) begin
        if (prev_vld_r) begin
          if (avg_vld_r) begin
            avg_r <= p_ah_r + AVG_BITS'(p_xh_r) + AVG_BITS'(p_lo_r);
          end else begin
            avg_r     <= xq_r;
            avg_vld_r <= 1'b1;
          end
        end
        prev_vld_r <= 1'b1;
        last_r     <= now_r;
        total_r    <= total_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) now_r <= in_now_us;
    if (cmd.win) begin
      closed_r   <= win_close;
      dropped_r  <= win_drop;
      fps_sat_r  <= (|frames_ext[31:FPS_BITS]) || (|prod_ext[39:FPS_BITS]);
      fps_cand_r <= prod_ext[FPS_BITS-1:0];
      interval_r <= ivl64[INTERVAL_BITS-1:0];
      xq_r       <= xq;
    end
    if (cmd.fps) begin
      divisor_r <= (fps_new == '0) ? FPS_BITS'(1) : fps_new;
      quo_r     <= {ideal_r, 16'b0};
      rem_r     <= '0;
      div_cnt_r <= '0;
      p_lo_r    <= lo_sum[32:16];
      p_ah_r    <= AVG_BITS'(avg_r[AVG_BITS-1:16]) * AVG_BITS'(EMA_KEEP);
      p_xh_r    <= (AVG_BITS-4)'(xq_r[AVG_BITS-1:16]) * (AVG_BITS-4)'(EMA_TAKE);
    end
    if (cmd.div_step) begin
      rem_r     <= ge ? diff[FPS_BITS-1:0] : shifted[FPS_BITS-1:0];
      quo_r     <= {quo_r[SCALE_BITS-2:0], ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.load_out) begin
      o_fps_r      <= fps_r;
      o_scale_r    <= quo_r;
      o_interval_r <= interval_r;
      o_avg_r      <= avg_r;
      o_closed_r   <= closed_r;
      o_dropped_r  <= dropped_r;
      o_total_r    <= total_r;
    end
  end

  assign out_fps_out           = o_fps_r;
  assign out_time_scale_q16    = o_scale_r;
  assign out_frame_interval_us = o_interval_r;
  assign out_interval_avg_q8   = o_avg_r;
  assign out_window_closed     = o_closed_r;
  assign out_window_dropped    = o_dropped_r;
  assign out_total_frames      = o_total_r;

endmodule

// File: rtl/core/frame_rate_monitor_top.sv
`timescale 1ns / 1ps
// A beat accepted in ST_IDLE passes through ST_WIN, ST_FPS, ST_EMA, ST_DIV and ST_OUT
// before it shows on the result channel, and no new beat is taken until the state is back in ST_IDLE;
// in ST_DIV the 24-step restoring divider forms time_scale_q16, one quotient bit per cycle.
// The input takes the next beat while a finished result still waits in the output register.
// Reset (rst_n low, synchronous): window, fps, average and frame count cleared,
// configuration registers back to their defaults, no result pending.
module frame_rate_monitor_top #(
  parameter int TIME_BITS  = 48,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [frm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [frm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [TIME_BITS-1:0]              in_now_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [frm_pkg::FPS_BITS-1:0]      out_fps_out,
  output logic [frm_pkg::SCALE_BITS-1:0]    out_time_scale_q16,
  output logic [frm_pkg::INTERVAL_BITS-1:0] out_frame_interval_us,
  output logic [frm_pkg::AVG_BITS-1:0]      out_interval_avg_q8,
  output logic                              out_window_closed,
  output logic                              out_window_dropped,
  output logic [frm_pkg::TOTAL_BITS-1:0]    out_total_frames
);
  import frm_pkg::*;

  frm_cmd_t  cmd;
  frm_stat_t stat;

  frm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  frm_dpath #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_now_us             (in_now_us),
    .cmd                   (cmd),
    .stat                  (stat),
    .out_fps_out           (out_fps_out),
    .out_time_scale_q16    (out_time_scale_q16),
    .out_frame_interval_us (out_frame_interval_us),
    .out_interval_avg_q8   (out_interval_avg_q8),
    .out_window_closed     (out_window_closed),
    .out_window_dropped    (out_window_dropped),
    .out_total_frames      (out_total_frames)
  );

endmodule

// File: rtl/core/frm_checker.sv
`timescale 1ns / 1ps
module frm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [frm_pkg::FPS_BITS-1:0]      out_fps_out,
  input logic [frm_pkg::SCALE_BITS-1:0]    out_time_scale_q16,
  input logic [frm_pkg::AVG_BITS-1:0]      out_interval_avg_q8,
  input logic                              out_window_closed,
  input logic                              out_window_dropped,
  input logic [frm_pkg::TOTAL_BITS-1:0]    out_total_frames
);
  import frm_pkg::*;

  // a pending result beat stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_fps_out) && $stable(out_time_scale_q16)
      && $stable(out_interval_avg_q8) && $stable(out_total_frames))
    else $error("stalled result beat changed");

  a_close_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_window_closed && out_window_dropped))
    else $error("window both closed and dropped");

  // one frame in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a frame is still in work");

endmodule

bind frame_rate_monitor_top frm_checker u_frm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_fps_out         (out_fps_out),
  .out_time_scale_q16  (out_time_scale_q16),
  .out_interval_avg_q8 (out_interval_avg_q8),
  .out_window_closed   (out_window_closed),
  .out_window_dropped  (out_window_dropped),
  .out_total_frames    (out_total_frames)
);

// File: sim/frame_rate_monitor_top_tb.sv
`timescale 1ns / 1ps
module frame_rate_monitor_top_tb;
  import frm_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 4'hF;

  typedef struct {
    logic [FPS_BITS-1:0]      fps;
    logic [SCALE_BITS-1:0]    scale;
    logic [INTERVAL_BITS-1:0] interval;
    logic [AVG_BITS-1:0]      avg;
    logic                     closed;
    logic                     dropped;
    logic [TOTAL_BITS-1:0]    total;
  } frame_report_t;

  typedef struct {
    logic [47:0]   stamp;
    bit            typed;
    frame_report_t want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [47:0]               in_now_us = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [FPS_BITS-1:0]       out_fps_out;
  logic [SCALE_BITS-1:0]     out_time_scale_q16;
  logic [INTERVAL_BITS-1:0]  out_frame_interval_us;
  logic [AVG_BITS-1:0]       out_interval_avg_q8;
  logic                      out_window_closed;
  logic                      out_window_dropped;
  logic [TOTAL_BITS-1:0]     out_total_frames;

  // meter model state and its copy of the registers
  logic [IDEAL_BITS-1:0] cfg_ideal;
  logic [WIN_BITS-1:0]   cfg_min;
  logic [WIN_BITS-1:0]   cfg_max;
  logic [MULT_BITS-1:0]  cfg_mult;
  logic [47:0]           win_start;
  logic [15:0]           win_count;
  logic [FPS_BITS-1:0]   fps_now;
  logic [47:0]           prev_stamp;
  logic [AVG_BITS-1:0]   avg_q8;
  logic [TOTAL_BITS-1:0] frame_count;
  bit                    seen_frame;
  bit                    avg_seeded;

  frame_report_t pending_reports[$];
  frame_report_t got_report;
  frame_report_t want_report;
  stim_row_t     plan[$];
  int            mismatches = 0;
  int            hold_cnt = 0;
  bit            idle_on = 1'b1;

  frame_rate_monitor_top uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_now_us             (in_now_us),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_fps_out           (out_fps_out),
    .out_time_scale_q16    (out_time_scale_q16),
    .out_frame_interval_us (out_frame_interval_us),
    .out_interval_avg_q8   (out_interval_avg_q8),
    .out_window_closed     (out_window_closed),
    .out_window_dropped    (out_window_dropped),
    .out_total_frames      (out_total_frames)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  task automatic reset_meter();
    cfg_ideal   = IDEAL_RESET;
    cfg_min     = MIN_RESET;
    cfg_max     = MAX_RESET;
    cfg_mult    = MULT_RESET;
    win_start   = '0;
    win_count   = '0;
    fps_now     = '0;
    prev_stamp  = '0;
    avg_q8      = '0;
    frame_count = '0;
    seen_frame  = 1'b0;
    avg_seeded  = 1'b0;
  endtask

  // advance the meter by one frame event and return what it reports
  function automatic frame_report_t meter_frame(input logic [47:0] stamp);
    frame_report_t r;
    logic [47:0]   elapsed;
    logic [63:0]   prod;
    logic [63:0]   num;
    logic [19:0]   div;
    logic [79:0]   acc;
    logic [55:0]   xq;
    elapsed   = stamp - win_start;
    r.closed  = 1'b0;
    r.dropped = 1'b0;
    if (win_count != 16'hFFFF) win_count = win_count + 16'd1;
    if (elapsed > 48'(cfg_min) && elapsed < 48'(cfg_max)) begin
      prod      = 64'(win_count) * 64'(cfg_mult);
      fps_now   = (prod > 64'hF_FFFF) ? 20'hF_FFFF : prod[19:0];
      win_start = stamp;
      win_count = '0;
      r.closed  = 1'b1;
    end else if (elapsed > 48'(cfg_max)) begin
      win_start = stamp;
      win_count = '0;
      r.dropped = 1'b1;
    end
    div         = (fps_now > 20'd1) ? fps_now : 20'd1;
    num         = 64'(cfg_ideal) << 16;
    r.scale     = 24'(num / 64'(div));
    frame_count = frame_count + 32'd1;
    r.interval  = stamp - prev_stamp;
    xq          = {r.interval, 8'h00};
    if (seen_frame) begin
      if (avg_seeded) begin
        acc    = 80'(avg_q8) * 80'(EMA_KEEP) + 80'(xq) * 80'(EMA_TAKE);
        avg_q8 = acc[71:16];
      end else begin
        avg_q8     = xq;
        avg_seeded = 1'b1;
      end
    end
    seen_frame = 1'b1;
    prev_stamp = stamp;
    r.fps      = fps_now;
    r.avg      = avg_q8;
    r.total    = frame_count;
    return r;
  endfunction

  task automatic send_frame(input logic [47:0] stamp, input bit typed,
                            input frame_report_t want);
    frame_report_t calc;
    int            gap;
    in_valid  <= 1'b1;
    in_now_us <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = meter_frame(stamp);
    pending_reports.push_back(typed ? want : calc);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and hold until every report has come back
  task automatic settle();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data, input bit last_one);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IDEAL_FPS:       cfg_ideal = data[IDEAL_BITS-1:0];
      REG_WINDOW_MIN_US:   cfg_min   = data[WIN_BITS-1:0];
      REG_WINDOW_MAX_US:   cfg_max   = data[WIN_BITS-1:0];
      REG_RATE_MULTIPLIER: cfg_mult  = data[MULT_BITS-1:0];
      default: ;
    endcase
    if (last_one) cfg_valid <= 1'b0;
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic program_meter(input logic [7:0] ideal, input logic [23:0] wmin,
                               input logic [23:0] wmax, input logic [4:0] mult);
    write_reg(REG_IDEAL_FPS, {16'($urandom), ideal}, 1'b0);
    write_reg(REG_WINDOW_MIN_US, wmin, 1'b0);
    write_reg(REG_WINDOW_MAX_US, wmax, 1'b0);
    write_reg(REG_RATE_MULTIPLIER, {19'($urandom), mult}, 1'b0);
    write_reg(REG_SPARE, 24'($urandom), 1'b1);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected 0x%0h got 0x%0h at %0t", what, want_v, got_v, $time);
  endtask

  // output stalls
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      hold_cnt = pick_gap();
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_report.fps      = out_fps_out;
      got_report.scale    = out_time_scale_q16;
      got_report.interval = out_frame_interval_us;
      got_report.avg      = out_interval_avg_q8;
      got_report.closed   = out_window_closed;
      got_report.dropped  = out_window_dropped;
      got_report.total    = out_total_frames;
      if (pending_reports.size() == 0) begin
        flag_mismatch("unexpected beat, total_frames", '0, 64'(got_report.total));
      end else begin
        want_report = pending_reports.pop_front();
        if (got_report.fps !== want_report.fps)
          flag_mismatch("fps_out", 64'(want_report.fps), 64'(got_report.fps));
        if (got_report.scale !== want_report.scale)
          flag_mismatch("time_scale_q16", 64'(want_report.scale), 64'(got_report.scale));
        if (got_report.interval !== want_report.interval)
          flag_mismatch("frame_interval_us", 64'(want_report.interval),
                        64'(got_report.interval));
        if (got_report.avg !== want_report.avg)
          flag_mismatch("interval_avg_q8", 64'(want_report.avg), 64'(got_report.avg));
        if (got_report.closed !== want_report.closed)
          flag_mismatch("window_closed", 64'(want_report.closed), 64'(got_report.closed));
        if (got_report.dropped !== want_report.dropped)
          flag_mismatch("window_dropped", 64'(want_report.dropped),
                        64'(got_report.dropped));
        if (got_report.total !== want_report.total)
          flag_mismatch("total_frames", 64'(want_report.total), 64'(got_report.total));
      end
    end
  end

  initial begin
    logic [47:0] stamp;
    logic [47:0] span;
    logic [7:0]  ideal_v;
    logic [23:0] min_v;
    logic [23:0] max_v;
    logic [4:0]  mult_v;
    int          r;
    frame_report_t blank;
    blank = '{default: '0};
    reset_meter();

    // first frame measures from zero and leaves the average alone; second seeds it
    plan.push_back('{48'd0, 1'b1,
                     '{20'd0, 24'd3932160, 48'd0, 56'd0, 1'b0, 1'b0, 32'd1}});
    plan.push_back('{48'd100, 1'b1,
                     '{20'd0, 24'd3932160, 48'd100, 56'd25600, 1'b0, 1'b0, 32'd2}});
    plan.push_back('{48'd250000, 1'b0, blank});          // elapsed equal to minimum
    plan.push_back('{48'd250001, 1'b0, blank});          // closes the window
    plan.push_back('{48'd1250001, 1'b0, blank});         // elapsed equal to maximum
    plan.push_back('{48'd1250002, 1'b0, blank});         // dropped
    plan.push_back('{48'd1250002, 1'b0, blank});         // zero interval
    plan.push_back('{48'd1250003, 1'b0, blank});
    plan.push_back('{48'hFFFF_FFFF_FFFF, 1'b0, blank});
    plan.push_back('{48'd0, 1'b0, blank});               // timestamp wraps
    plan.push_back('{48'd300000, 1'b0, blank});
    plan.push_back('{48'd600000, 1'b0, blank});
    plan.push_back('{48'h8000_0000_0000, 1'b0, blank});
    plan.push_back('{48'h5555_5555_5555, 1'b0, blank});
    plan.push_back('{48'hAAAA_AAAA_AAAA, 1'b0, blank});
    plan.push_back('{48'h0000_0000_0001, 1'b0, blank}); // backwards in time

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_frame(plan[i].stamp, plan[i].typed, plan[i].want);
    stamp = prev_stamp;

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: program_meter(8'd255, 24'd0, 24'hFF_FFFF, 5'd31);
        1: program_meter(8'd0, 24'd0, 24'd0, 5'd0);
        2: program_meter(8'd1, 24'd5000, 24'd2000, 5'd1);
        default: begin
          ideal_v = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(1, 255));
          if ($urandom_range(0, 7) == 0) begin
            min_v = 24'($urandom);
            max_v = 24'($urandom);
          end else begin
            min_v = 24'($urandom_range(0, 3000));
            max_v = min_v + 24'($urandom_range(1, 6000));
          end
          mult_v = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 16));
          program_meter(ideal_v, min_v, max_v, mult_v);
        end
      endcase
      idle_on = (p != 5);
      span = 48'((cfg_max > cfg_min) ? cfg_max : cfg_min) / 48'd5 + 48'd1;
      for (int k = 0; k < 88; k++) begin
        if (p == 6 && k == 40) settle();
        r = $urandom_range(0, 99);
        if (r < 72)
          stamp = stamp + 48'($urandom_range(0, 32'(span)));
        else if (r < 78)
          stamp = win_start + 48'(cfg_min) + 48'($urandom_range(0, 1));
        else if (r < 84)
          stamp = win_start + 48'(cfg_max) + 48'($urandom_range(0, 1));
        else if (r < 91)
          stamp = stamp + 48'($urandom_range(0, 32'h0FFF_FFFF));
        else if (r < 97)
          stamp = 48'({$urandom, $urandom});
        else
          stamp = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 50));
        send_frame(stamp, 1'b0, blank);
      end
    end

    idle_on = 1'b1;
    settle();
    repeat (64) @(posedge clk);
    if (pending_reports.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
